FILE: design/postfix_expression_evaluator_top_assert.svh
// Assertion macros used by the checker file pee_checker.sv.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
// Implication that must hold at every clock edge outside reset.
`define PEE_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Implication checked on the next clock edge.
`define PEE_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

FILE: design/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Types and character codes of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;
   localparam int VAL_W = 48;
   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_UNDER = 2'd1;
   localparam status_type ST_OVER  = 2'd2;
   localparam status_type ST_DIVZ  = 2'd3;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_TIMES = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
endpackage

FILE: design/postfix_expression_evaluator_top.sv
// Postfix expression evaluator over an operand stack held in one RAM.
// After a word is taken the block stays busy, and takes no new word, until it returns to
// S_IDLE. Times forms four 32x32-bit partial products, one per cycle; divide runs the
// one-bit-per-cycle restoring divider; divide by zero pushes a saturated value.
// A last word then reads the stack top, and waits while the previous result word still waits.
// Reset (synchronous, active high) empties the stack and clears the error; the RAM is kept.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Reads operands from the stack RAM, computes, writes the result back.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top #(
   parameter int STACK_DEPTH = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // symbol[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // value[47:0], status[49:48], zeros above
);
   import pee_pkg::*;
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int NB = VAL_W + FRAC_BITS;  // dividend bits
   localparam int DCW = $clog2(NB + 1);
   localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_RD0, S_EXEC, S_ADD, S_MUL, S_MULF, S_DIV, S_DIVF, S_PUSH, S_TOP,
      S_OUT
   } state_type;

   state_type  state_ff;
   logic [CW-1:0] count_ff;
   status_type err_ff;
   logic [7:0] sym_ff;
   logic       last_ff;
   logic [VAL_W-1:0] x_ff, y_ff, res_ff;
   logic       neg_ff;
   logic [63:0] a_ff, b_ff;
   logic [127:0] prod_ff;
   logic [1:0] pp_ff;
   logic [NB-1:0] num_ff;
   logic [VAL_W-1:0] rem_ff;
   logic [NB-1:0] quo_ff;
   logic [DCW-1:0] dcnt_ff;
   logic       rvalid_ff;
   logic [VAL_W-1:0] rvalue_ff;
   status_type rstatus_ff;

   logic [VAL_W-1:0] mem [STACK_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic rd_en, wr_en;
   logic [VAL_W-1:0] wr_data;

   logic is_digit, is_op;
   assign is_digit = (sym_ff >= CH_ZERO) && (sym_ff <= CH_NINE);
   assign is_op = (sym_ff == CH_PLUS) || (sym_ff == CH_MINUS) ||
                  (sym_ff == CH_TIMES) || (sym_ff == CH_SLASH);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = {6'd0, rstatus_ff, rvalue_ff};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = res_ff;
      case (state_ff)
         S_RD1: begin rd_en = 1'b1; rd_addr = AW'(count_ff - CW'(1)); end
         S_RD0: begin rd_en = 1'b1; rd_addr = AW'(count_ff - CW'(2)); end
         S_TOP: begin rd_en = 1'b1; rd_addr = AW'(count_ff - CW'(1)); end
         S_PUSH: wr_en = (count_ff < CW'(STACK_DEPTH));
         default: ;
      endcase
   end

   // Arithmetic helpers.
   logic signed [VAL_W:0] sum;
   logic [VAL_W-1:0] sum_sat;
   logic [VAL_W:0] trial;
   logic [VAL_W-1:0] mag_x, mag_y;
   logic [31:0] mul_a, mul_b;
   logic [63:0] pp64;
   logic [127:0] pp;
   logic [127:0] shifted;
   logic [VAL_W-1:0] mul_res, div_res;
   logic [127:0] qwide;
   always_comb begin
      if (sym_ff == CH_MINUS) sum = {x_ff[VAL_W-1], x_ff} - {y_ff[VAL_W-1], y_ff};
      else sum = {x_ff[VAL_W-1], x_ff} + {y_ff[VAL_W-1], y_ff};
      if (sum[VAL_W] != sum[VAL_W-1]) sum_sat = sum[VAL_W] ? VMIN : VMAX;
      else sum_sat = sum[VAL_W-1:0];
      // The left operand arrives from the RAM in S_EXEC, the right one sits in y_ff.
      mag_x = rd_data_ff[VAL_W-1] ? (~rd_data_ff) + VAL_W'(1) : rd_data_ff;
      mag_y = y_ff[VAL_W-1] ? (~y_ff) + VAL_W'(1) : y_ff;
      mul_a = pp_ff[1] ? a_ff[63:32] : a_ff[31:0];
      mul_b = pp_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp64 = mul_a * mul_b;
      case (pp_ff)
         2'd0: pp = {64'd0, pp64};
         2'd1, 2'd2: pp = {32'd0, pp64, 32'd0};
         default: pp = {pp64, 64'd0};
      endcase
      shifted = prod_ff >> FRAC_BITS;
      if (shifted >= 128'(VMIN)) mul_res = neg_ff ? VMIN : VMAX;
      else mul_res = neg_ff ? (~shifted[VAL_W-1:0]) + VAL_W'(1) : shifted[VAL_W-1:0];
      qwide = 128'(quo_ff);
      if (qwide >= 128'(VMIN)) div_res = neg_ff ? VMIN : VMAX;
      else div_res = neg_ff ? (~quo_ff[VAL_W-1:0]) + VAL_W'(1) : quo_ff[VAL_W-1:0];
      trial = {rem_ff, num_ff[NB-1]} - {1'b0, b_ff[VAL_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         err_ff <= ST_OK;
         rvalid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rvalid_ff || rsp_tready)) rvalid_ff <= 1'b1;
         else if (rvalid_ff && rsp_tready) rvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               sym_ff <= req_tdata;
               last_ff <= req_tlast;
               state_ff <= S_RD1;
            end
            S_RD1: begin
               if (is_digit) begin
                  res_ff <= VAL_W'({44'd0, 4'(sym_ff - CH_ZERO)}) << FRAC_BITS;
                  state_ff <= S_PUSH;
               end else if (is_op) begin
                  if (count_ff < CW'(2)) begin
                     if (err_ff == ST_OK) err_ff <= ST_UNDER;
                     state_ff <= last_ff ? S_TOP : S_IDLE;
                  end else state_ff <= S_RD0;
               end else state_ff <= last_ff ? S_TOP : S_IDLE;
            end
            S_RD0: begin
               y_ff <= rd_data_ff;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               x_ff <= rd_data_ff;
               count_ff <= count_ff - CW'(2);
               neg_ff <= rd_data_ff[VAL_W-1] ^ y_ff[VAL_W-1];
               a_ff <= 64'(mag_x);
               b_ff <= 64'(mag_y);
               prod_ff <= '0;
               pp_ff <= 2'd0;
               num_ff <= NB'(mag_x) << FRAC_BITS;
               rem_ff <= '0;
               quo_ff <= '0;
               dcnt_ff <= DCW'(NB);
               if (sym_ff == CH_TIMES) state_ff <= S_MUL;
               else if (sym_ff == CH_SLASH) begin
                  if (y_ff == '0) begin
                     if (err_ff == ST_OK) err_ff <= ST_DIVZ;
                     res_ff <= rd_data_ff[VAL_W-1] ? VMIN : VMAX;
                     state_ff <= S_PUSH;
                  end else state_ff <= S_DIV;
               end else state_ff <= S_ADD;
            end
            S_ADD: begin
               res_ff <= sum_sat;
               state_ff <= S_PUSH;
            end
            S_MUL: begin
               prod_ff <= prod_ff + pp;
               pp_ff <= pp_ff + 2'd1;
               if (pp_ff == 2'd3) state_ff <= S_MULF;
            end
            S_MULF: begin
               res_ff <= mul_res;
               state_ff <= S_PUSH;
            end
            S_DIV: begin
               num_ff <= num_ff << 1;
               if (!trial[VAL_W]) begin
                  rem_ff <= trial[VAL_W-1:0];
                  quo_ff <= {quo_ff[NB-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[VAL_W-2:0], num_ff[NB-1]};
                  quo_ff <= {quo_ff[NB-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - DCW'(1);
               if (dcnt_ff == DCW'(1)) state_ff <= S_DIVF;
            end
            S_DIVF: begin
               res_ff <= div_res;
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (count_ff < CW'(STACK_DEPTH)) count_ff <= count_ff + CW'(1);
               else if (err_ff == ST_OK) err_ff <= ST_OVER;
               state_ff <= last_ff ? S_TOP : S_IDLE;
            end
            S_TOP: state_ff <= S_OUT;
            S_OUT: if (!rvalid_ff || rsp_tready) begin
               if (count_ff == '0) begin
                  rvalue_ff <= '0;
                  rstatus_ff <= (err_ff == ST_OK) ? ST_UNDER : err_ff;
               end else begin
                  rvalue_ff <= rd_data_ff;
                  rstatus_ff <= err_ff;
               end
               count_ff <= '0;
               err_ff <= ST_OK;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: design/pee_checker.sv
// ----------------------------------------------------------------------------
// pee_checker
// Port-level checks of the postfix expression evaluator, bound to the top.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_top_assert.svh"
module pee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   `PEE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word dropped while stalled")
   `PEE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "second word taken while busy")
   `PEE_ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[55:50] == 6'd0, "padding bits not zero")
endmodule

bind postfix_expression_evaluator_top pee_checker u_pee_checker (.*);

FILE: tb/tb_postfix_expression_evaluator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator_top
// Drives postfix expressions into the evaluator and checks every result word
// against a fixed-point stack calculator kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator_top;
   import pee_pkg::*;

   localparam int DEPTH = 64;
   localparam int FRAC  = 16;
   localparam longint LIMIT = 3000000;
   localparam logic signed [47:0] MAX_VAL = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] MIN_VAL = 48'sh8000_0000_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   postfix_expression_evaluator_top #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FRAC)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Calculator state.
   logic signed [47:0] calc_stack [DEPTH];
   int                 calc_count = 0;
   status_type         calc_err = ST_OK;
   value_type          want_value [$];
   status_type         want_status [$];

   int     errors = 0;
   int     n_items = 0;
   int     n_words = 0;
   longint cycles = 0;
   bit     calm = 1'b0;

   task automatic report(input string what);
      errors++;
      $display("MISMATCH at cycle %0d: %s", cycles, what);
   endtask

   function automatic logic signed [47:0] saturate(input logic signed [127:0] v);
      if (v > 128'(signed'(MAX_VAL))) return MAX_VAL;
      if (v < 128'(signed'(MIN_VAL))) return MIN_VAL;
      return v[47:0];
   endfunction

   function automatic void flag(input status_type e);
      if (calc_err == ST_OK) calc_err = e;
   endfunction

   function automatic void push(input logic signed [47:0] v);
      if (calc_count >= DEPTH) flag(ST_OVER);
      else begin
         calc_stack[calc_count] = v;
         calc_count++;
      end
   endfunction

   function automatic void evaluate(input logic [7:0] sym, input bit last);
      logic signed [127:0] x, y, r;
      logic [127:0] mx, my, mq;
      bit neg;
      if (sym >= CH_ZERO && sym <= CH_NINE) begin
         push(48'(sym - CH_ZERO) << FRAC);
      end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_TIMES
                   || sym == CH_SLASH) begin
         if (calc_count < 2) flag(ST_UNDER);
         else begin
            y = calc_stack[calc_count-1];
            x = calc_stack[calc_count-2];
            calc_count -= 2;
            mx = x < 0 ? -x : x;
            my = y < 0 ? -y : y;
            neg = (x < 0) != (y < 0);
            case (sym)
               CH_PLUS:  r = x + y;
               CH_MINUS: r = x - y;
               CH_TIMES: begin
                  mq = (mx * my) >> FRAC;
                  r = neg ? -$signed(mq) : $signed(mq);
               end
               default: begin
                  if (my == 0) begin
                     flag(ST_DIVZ);
                     r = x < 0 ? 128'(signed'(MIN_VAL)) : 128'(signed'(MAX_VAL));
                  end else begin
                     // Magnitudes stay below 2^64, so the quotient never wraps.
                     mq = (mx << FRAC) / my;
                     r = neg ? -$signed(mq) : $signed(mq);
                  end
               end
            endcase
            push(saturate(r));
         end
      end
      if (last) begin
         if (calc_count == 0) begin
            flag(ST_UNDER);
            want_value.push_back('0);
         end else want_value.push_back(calc_stack[calc_count-1]);
         want_status.push_back(calc_err);
         calc_count = 0;
         calc_err = ST_OK;
      end
   endfunction

   // The word stays valid after it is taken until the next one replaces it or
   // an idle cycle drops it.
   task automatic send_symbol(input logic [7:0] sym, input bit last);
      while (!calm && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      evaluate(sym, last);
      n_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_symbol(s[i], i == s.len() - 1);
   endtask

   // Result checker with random back-pressure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_words++;
         if (want_value.size() == 0) report("result word with nothing expected");
         else begin
            if (rsp_tdata[47:0] !== want_value[0])
               report($sformatf("value %h, expected %h", rsp_tdata[47:0], want_value[0]));
            if (rsp_tdata[49:48] !== want_status[0])
               report($sformatf("status %0d, expected %0d", rsp_tdata[49:48],
                                want_status[0]));
            if (rsp_tdata[55:50] !== '0) report("padding bits not zero");
            void'(want_value.pop_front());
            void'(want_status.pop_front());
         end
      end
      rsp_tready <= calm || ($urandom_range(99) >= 24);
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_directed;
      send_text("34+");
      send_text("92-");
      send_text("78*");
      send_text("91/");
      send_text("50/");
      send_text("05-0/");
      send_text("+");
      send_text("5");
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hFF, 1'b1);
      send_text("1a2b+");
      send_text("123++");
      send_text("9+8");
   endtask

   task automatic test_saturation;
      // Multiply by nine repeatedly to drive the multiplier into saturation.
      send_symbol("9", 0);
      for (int i = 0; i < 6; i++) begin
         send_symbol("9", 0);
         send_symbol("*", 0);
         send_symbol("9", 0);
         send_symbol("*", 0);
      end
      send_symbol("9", 0); send_symbol("*", 0);
      send_symbol("0", 0); send_symbol("9", 0); send_symbol("-", 0);
      send_symbol("*", 1);
      send_symbol("1", 0); send_symbol("9", 0);
      for (int i = 0; i < 7; i++) begin
         send_symbol("/", 0);
         send_symbol("9", 0);
      end
      send_symbol("/", 1);
   endtask

   task automatic test_full_stack;
      for (int i = 0; i < DEPTH + 2; i++) send_symbol(8'(CH_ZERO + i % 10), 0);
      send_symbol("+", 1);
   endtask

   task automatic test_random;
      int depth;
      int n;
      logic [7:0] s;
      byte ops [4] = '{CH_PLUS, CH_MINUS, CH_TIMES, CH_SLASH};
      while (n_items < 1100) begin
         if (n_items > 700 && n_items < 850) calm = 1'b1; else calm = 1'b0;
         if ($urandom_range(9) < 8) begin
            // Well-formed expression of a few operands.
            depth = 0;
            n = $urandom_range(1, 8);
            for (int k = 0; k < n || depth > 1; k++) begin
               if (depth >= 2 && (k >= n || $urandom_range(1))) begin
                  send_symbol(ops[$urandom_range(3)], depth == 2 && k >= n);
                  depth--;
               end else begin
                  send_symbol(8'(CH_ZERO + $urandom_range(9)), k >= n && depth == 0);
                  depth++;
               end
            end
            if (calc_count > 0) send_symbol(8'($urandom_range(255)) | 8'h80, 1);
         end else begin
            for (int k = $urandom_range(1, 10); k > 0; k--) begin
               s = 8'($urandom_range(255));
               send_symbol(s, k == 1);
            end
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed;
      test_saturation;
      test_full_stack;
      test_random;
      req_tvalid <= 1'b0;
      while (want_value.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d characters, checked %0d result words, covering digits,",
               n_items, n_words);
      $display("all four operators, saturation, divide by zero and stack errors.");
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+design
design/pee_pkg.sv
design/postfix_expression_evaluator_top.sv
design/pee_checker.sv
tb/tb_postfix_expression_evaluator_top.sv
